FILE: rtl/ps2_scancode_to_ascii_defines.svh
// assertion macros used by the scancode decoder rtl
// no dependencies; included by ps2s2a_burst, the file that carries concurrent checks
`ifndef PS2_SCANCODE_TO_ASCII_DEFINES_SVH
`define PS2_SCANCODE_TO_ASCII_DEFINES_SVH

// plain property check, disabled while in reset
`define PS2S2A_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// overlapping implication check
`define PS2S2A_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication check
`define PS2S2A_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ps2s2a_pkg.sv
// types, scancode constants and key translation tables for the decoder
// no dependencies
package ps2s2a_pkg;

  localparam logic [7:0] ScanPrefix = 8'hE0;
  localparam logic [7:0] ScanPause  = 8'hE1;
  localparam logic [7:0] ScanAck    = 8'hFA;
  localparam logic [7:0] ScanResend = 8'hFE;

  localparam logic [6:0] KeyShiftL = 7'h2A;
  localparam logic [6:0] KeyShiftR = 7'h36;
  localparam logic [6:0] KeyCtrl   = 7'h1D;
  localparam logic [6:0] KeyAlt    = 7'h38;
  localparam logic [6:0] KeyCaps   = 7'h3A;
  localparam logic [6:0] KeyUp     = 7'h48;
  localparam logic [6:0] KeyDown   = 7'h50;
  localparam logic [6:0] KeyLeft   = 7'h4B;
  localparam logic [6:0] KeyRight  = 7'h4D;
  localparam logic [6:0] KeyDelete = 7'h53;

  localparam logic [6:0] ChNone    = 7'h00;
  localparam logic [6:0] ChEsc     = 7'h1B;
  localparam logic [6:0] ChFs      = 7'h1C;
  localparam logic [6:0] ChGs      = 7'h1D;
  localparam logic [6:0] ChLBrack  = 7'h5B;
  localparam logic [6:0] ChBslash  = 7'h5C;
  localparam logic [6:0] ChRBrack  = 7'h5D;
  localparam logic [6:0] ChTilde   = 7'h7E;
  localparam logic [6:0] ChUpperA  = 7'h41;
  localparam logic [6:0] ChUpperB  = 7'h42;
  localparam logic [6:0] ChUpperC  = 7'h43;
  localparam logic [6:0] ChUpperD  = 7'h44;
  localparam logic [6:0] ChDigit3  = 7'h33;
  localparam logic [6:0] ChLowerA  = 7'h61;
  localparam logic [6:0] ChLowerZ  = 7'h7A;
  localparam logic [6:0] CaseDiff  = 7'h20;
  localparam logic [6:0] CtrlDiff  = 7'h60;

  localparam int unsigned MaxChars = 4;

  typedef struct packed {
    logic prefix;
    logic shift_l;
    logic shift_r;
    logic ctrl_l;
    logic ctrl_r;
    logic alt_l;
    logic alt_r;
    logic caps;
  } key_state_t;

  // everything one scancode byte produces
  typedef struct packed {
    logic [2:0]                 nchar;
    logic [MaxChars-1:0][6:0]   chars;
    logic [6:0]                 key_code;
    logic                       pressed;
    logic                       extended;
    logic [6:0]                 ev_char;
    logic [3:0]                 mods;
  } burst_t;

  typedef struct packed {
    logic       kind;
    logic [6:0] char_value;
    logic [6:0] key_code;
    logic       pressed;
    logic       extended;
    logic [3:0] modifiers;
    logic       last;
  } item_t;

  function automatic logic [6:0] base_char(input logic [6:0] code);
    logic [6:0] c;
    case (code)
      7'h01: c = 7'h1B;  7'h02: c = 7'h31;  7'h03: c = 7'h32;  7'h04: c = 7'h33;
      7'h05: c = 7'h34;  7'h06: c = 7'h35;  7'h07: c = 7'h36;  7'h08: c = 7'h37;
      7'h09: c = 7'h38;  7'h0A: c = 7'h39;  7'h0B: c = 7'h30;  7'h0C: c = 7'h2D;
      7'h0D: c = 7'h3D;  7'h0E: c = 7'h08;  7'h0F: c = 7'h09;
      7'h10: c = 7'h71;  7'h11: c = 7'h77;  7'h12: c = 7'h65;  7'h13: c = 7'h72;
      7'h14: c = 7'h74;  7'h15: c = 7'h79;  7'h16: c = 7'h75;  7'h17: c = 7'h69;
      7'h18: c = 7'h6F;  7'h19: c = 7'h70;  7'h1A: c = 7'h5B;  7'h1B: c = 7'h5D;
      7'h1C: c = 7'h0A;  7'h1E: c = 7'h61;  7'h1F: c = 7'h73;
      7'h20: c = 7'h64;  7'h21: c = 7'h66;  7'h22: c = 7'h67;  7'h23: c = 7'h68;
      7'h24: c = 7'h6A;  7'h25: c = 7'h6B;  7'h26: c = 7'h6C;  7'h27: c = 7'h3B;
      7'h28: c = 7'h27;  7'h29: c = 7'h60;  7'h2B: c = 7'h5C;  7'h2C: c = 7'h7A;
      7'h2D: c = 7'h78;  7'h2E: c = 7'h63;  7'h2F: c = 7'h76;
      7'h30: c = 7'h62;  7'h31: c = 7'h6E;  7'h32: c = 7'h6D;  7'h33: c = 7'h2C;
      7'h34: c = 7'h2E;  7'h35: c = 7'h2F;  7'h37: c = 7'h2A;  7'h39: c = 7'h20;
      7'h4A: c = 7'h2D;  7'h4E: c = 7'h2B;
      default: c = ChNone;
    endcase
    return c;
  endfunction

  // shifted symbols of the non-letter keys
  function automatic logic [6:0] shift_char(input logic [6:0] code);
    logic [6:0] c;
    case (code)
      7'h02: c = 7'h21;  7'h03: c = 7'h40;  7'h04: c = 7'h23;  7'h05: c = 7'h24;
      7'h06: c = 7'h25;  7'h07: c = 7'h5E;  7'h08: c = 7'h26;  7'h09: c = 7'h2A;
      7'h0A: c = 7'h28;  7'h0B: c = 7'h29;  7'h0C: c = 7'h5F;  7'h0D: c = 7'h2B;
      7'h1A: c = 7'h7B;  7'h1B: c = 7'h7D;  7'h27: c = 7'h3A;  7'h28: c = 7'h22;
      7'h29: c = 7'h7E;  7'h2B: c = 7'h7C;  7'h33: c = 7'h3C;  7'h34: c = 7'h3E;
      7'h35: c = 7'h3F;
      default: c = ChNone;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] translate_key(input logic [6:0] code, input logic shift,
                                               input logic ctrl, input logic caps);
    logic [6:0] base;
    logic [6:0] shifted;
    logic       letter;
    logic [6:0] c;
    base    = base_char(code);
    shifted = shift_char(code);
    letter  = (base >= ChLowerA) && (base <= ChLowerZ);
    if (base == ChNone) begin
      c = ChNone;
    end else if (ctrl && letter) begin
      c = base - CtrlDiff;
    end else if (ctrl && base == ChLBrack) begin
      c = ChEsc;
    end else if (ctrl && base == ChBslash) begin
      c = ChFs;
    end else if (ctrl && base == ChRBrack) begin
      c = ChGs;
    end else if (letter) begin
      c = (shift ^ caps) ? base - CaseDiff : base;
    end else if (shift && shifted != ChNone) begin
      c = shifted;
    end else begin
      c = base;
    end
    return c;
  endfunction

endpackage

FILE: rtl/ps2s2a_decode.sv
// scancode decoder: modifier and prefix state plus per-byte result burst
// depends on ps2s2a_pkg
module ps2s2a_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          scan_byte_i,
  output ps2s2a_pkg::burst_t  burst_o,
  output logic                has_items_o
);
  import ps2s2a_pkg::*;

  key_state_t st_q, st_d;
  logic [6:0] code;
  logic       press;
  logic [6:0] tail;
  logic [6:0] ch;

  assign code  = scan_byte_i[6:0];
  assign press = ~scan_byte_i[7];

  // escape sequence tail for the extended cursor and delete keys
  always_comb begin
    case (code)
      KeyUp:     tail = ChUpperA;
      KeyDown:   tail = ChUpperB;
      KeyLeft:   tail = ChUpperD;
      KeyRight:  tail = ChUpperC;
      KeyDelete: tail = ChDigit3;
      default:   tail = ChNone;
    endcase
  end

  assign ch = translate_key(code, st_q.shift_l | st_q.shift_r,
                            st_q.ctrl_l | st_q.ctrl_r, st_q.caps);

  always_comb begin
    st_d        = st_q;
    burst_o     = '0;
    has_items_o = 1'b0;
    if (scan_byte_i == ScanPrefix) begin
      st_d.prefix = 1'b1;
    end else if (scan_byte_i == ScanPause) begin
      st_d.prefix = 1'b0;
    end else if (scan_byte_i == ScanAck || scan_byte_i == ScanResend) begin
      st_d = st_q;
    end else begin
      has_items_o      = 1'b1;
      burst_o.key_code = code;
      burst_o.pressed  = press;
      if (st_q.prefix) begin
        st_d.prefix      = 1'b0;
        burst_o.extended = 1'b1;
        if (code == KeyCtrl) begin
          st_d.ctrl_r = press;
        end else if (code == KeyAlt) begin
          st_d.alt_r = press;
        end else if (press && tail != ChNone) begin
          burst_o.chars[0] = ChEsc;
          burst_o.chars[1] = ChLBrack;
          burst_o.chars[2] = tail;
          burst_o.chars[3] = ChTilde;
          burst_o.nchar    = (code == KeyDelete) ? 3'd4 : 3'd3;
        end
      end else if (code == KeyShiftL) begin
        st_d.shift_l = press;
      end else if (code == KeyShiftR) begin
        st_d.shift_r = press;
      end else if (code == KeyCtrl) begin
        st_d.ctrl_l = press;
      end else if (code == KeyAlt) begin
        st_d.alt_l = press;
      end else if (code == KeyCaps) begin
        st_d.caps = st_q.caps ^ press;
      end else if (press) begin
        burst_o.ev_char  = ch;
        burst_o.chars[0] = ch;
        burst_o.nchar    = (ch != ChNone) ? 3'd1 : 3'd0;
      end
    end
    // modifiers as they stand after this byte
    burst_o.mods = {st_d.caps, st_d.alt_l | st_d.alt_r, st_d.ctrl_l | st_d.ctrl_r,
                    st_d.shift_l | st_d.shift_r};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (accept_i) begin
      st_q <= st_d;
    end
  end

endmodule

FILE: rtl/ps2s2a_burst.sv
// result serialiser: holds one byte's burst and drains it through an output register
// depends on ps2s2a_pkg and ps2_scancode_to_ascii_defines.svh
module ps2s2a_burst (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  ps2s2a_pkg::burst_t  burst_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ps2s2a_pkg::item_t   out_item_o
);
  import ps2s2a_pkg::*;
  `include "ps2_scancode_to_ascii_defines.svh"

  burst_t     burst_q;
  logic       burst_valid_q;
  logic [2:0] idx_q;
  logic       out_valid_q;
  item_t      out_q;
  item_t      item;
  logic       out_free;
  logic       emit;
  logic       idx_last;

  assign out_free   = ~out_valid_q | out_ready_i;
  assign emit       = burst_valid_q & out_free;
  assign idx_last   = (idx_q == burst_q.nchar);
  assign in_ready_o = ~burst_valid_q | (emit & idx_last);

  // characters first, then the key event closing the burst
  always_comb begin
    item = '0;
    if (!idx_last) begin
      item.char_value = burst_q.chars[idx_q[1:0]];
    end else begin
      item.kind       = 1'b1;
      item.char_value = burst_q.ev_char;
      item.key_code   = burst_q.key_code;
      item.pressed    = burst_q.pressed;
      item.extended   = burst_q.extended;
      item.modifiers  = burst_q.mods;
      item.last       = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_valid_q <= 1'b0;
      idx_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (load_i) begin
        burst_valid_q <= 1'b1;
        idx_q         <= '0;
      end else if (emit && idx_last) begin
        burst_valid_q <= 1'b0;
      end else if (emit) begin
        idx_q <= idx_q + 3'd1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
    if (emit) begin
      out_q <= item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `PS2S2A_ASSERT_IMP(a_idx_range, clk_i, rst_ni, burst_valid_q, idx_q <= burst_q.nchar,
                     "burst index ran past its last item")
  `PS2S2A_ASSERT_IMP(a_nchar_max, clk_i, rst_ni, burst_valid_q, burst_q.nchar <= 3'd4,
                     "burst holds too many characters")
  `PS2S2A_ASSERT_IMP(a_load_free, clk_i, rst_ni, load_i, in_ready_o,
                     "burst loaded while previous one still draining")
  `PS2S2A_ASSERT_NXT(a_last_mark, clk_i, rst_ni, emit, out_q.last == $past(idx_last),
                     "last flag does not match end of burst")
endmodule

FILE: rtl/ps2_scancode_to_ascii.sv
// top level of the ps/2 scan code set 1 to ascii decoder
// depends on ps2s2a_pkg, ps2s2a_decode and ps2s2a_burst
//
//  channel   direction  tdata                                   tuser  tlast
//  s_axis    in         scan_byte                               -      -
//  m_axis    out        char_value,key_code,pressed,extended,   kind   last
//                       modifiers
//
// a byte is decoded as it is taken into the burst register; its first result then moves
// into the output register, from which it can transfer
// a byte giving n results (0 to 5) passes them through the output register one by one, so
// the sustained rate is one byte per cycle for single-result keys while the output does
// not stall, and an escape sequence holds the input; the result serialiser sets the pace
// reset clears the prefix, modifier and caps-lock flags and empties both stages
// output stalls reach the input while a burst is held; the next byte is taken in the
// cycle the burst's last item moves into the output register
module ps2_scancode_to_ascii (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] scan_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [6:0] char_value, [13:7] key_code, [14] pressed, [15] extended,
  // [19:16] modifiers, [23:20] zero
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast
);
  import ps2s2a_pkg::*;

  burst_t burst;
  logic   has_items;
  logic   accept;
  item_t  item;

  assign accept = s_axis_tvalid & s_axis_tready;

  ps2s2a_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .scan_byte_i (s_axis_tdata),
    .burst_o     (burst),
    .has_items_o (has_items)
  );

  ps2s2a_burst u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept & has_items),
    .burst_i     (burst),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (item)
  );

  assign m_axis_tdata = {4'b0000, item.modifiers, item.extended, item.pressed,
                         item.key_code, item.char_value};
  assign m_axis_tuser = item.kind;
  assign m_axis_tlast = item.last;

endmodule
